>>> hw/rtl/waad_pkg.sv
// Shared constants, microcode types and the control store of the
// windowed average anomaly detector. No dependencies.
package waad_pkg;

  // Field widths
  localparam int SAMPLE_W   = 32;
  localparam int RATIO_W    = 16;
  localparam int TOTAL_W    = 64;
  localparam int PROD_W     = SAMPLE_W + RATIO_W;
  localparam int FRAC_SHIFT = 8;

  // Defaults
  localparam int                 WINDOW_DEPTH_DEF = 16;
  localparam int                 MIN_STORED       = 3;
  localparam logic [RATIO_W-1:0] DEFAULT_RATIO    = 16'd512;

  // Datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,    // take an input beat, read the oldest window entry
    OP_MUL,       // baseline times ratio
    OP_CMP,       // anomaly flag
    OP_WIN,       // ring write, window sum, fill count, write slot
    OP_TOTAL,     // saturating grand total
    OP_DIV_INIT,  // load the divider
    OP_DIV_STEP   // one quotient bit
  } dp_op_t;

  // Jump conditions: taken goes to the target, else to the next step
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,      // no input beat this cycle
    C_DIV_MORE,   // quotient bits still to come
    C_OUT_BUSY    // result register still held by the receiver
  } jmp_cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    dp_op_t    op;
    logic      load_out;
    jmp_cond_t cond;
    step_t     target;
  } ucode_t;

  // Program steps
  localparam step_t ST_WAIT = 4'd0;
  localparam step_t ST_MUL  = 4'd1;
  localparam step_t ST_CMP  = 4'd2;
  localparam step_t ST_WIN  = 4'd3;
  localparam step_t ST_TOT  = 4'd4;
  localparam step_t ST_DIVI = 4'd5;
  localparam step_t ST_DIV  = 4'd6;
  localparam step_t ST_FIN  = 4'd7;
  localparam step_t ST_END  = 4'd8;

  // Control store
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    w = '{op: OP_NOP, load_out: 1'b0, cond: C_ALWAYS, target: ST_WAIT};
    case (pc)
      ST_WAIT: w = '{op: OP_ACCEPT,   load_out: 1'b0, cond: C_NO_IN,    target: ST_WAIT};
      ST_MUL:  w = '{op: OP_MUL,      load_out: 1'b0, cond: C_NONE,     target: ST_WAIT};
      ST_CMP:  w = '{op: OP_CMP,      load_out: 1'b0, cond: C_NONE,     target: ST_WAIT};
      ST_WIN:  w = '{op: OP_WIN,      load_out: 1'b0, cond: C_NONE,     target: ST_WAIT};
      ST_TOT:  w = '{op: OP_TOTAL,    load_out: 1'b0, cond: C_NONE,     target: ST_WAIT};
      ST_DIVI: w = '{op: OP_DIV_INIT, load_out: 1'b0, cond: C_NONE,     target: ST_WAIT};
      ST_DIV:  w = '{op: OP_DIV_STEP, load_out: 1'b0, cond: C_DIV_MORE, target: ST_DIV};
      ST_FIN:  w = '{op: OP_NOP,      load_out: 1'b1, cond: C_OUT_BUSY, target: ST_FIN};
      ST_END:  w = '{op: OP_NOP,      load_out: 1'b0, cond: C_ALWAYS,   target: ST_WAIT};
      default: w = '{op: OP_NOP,      load_out: 1'b0, cond: C_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/windowed_average_anomaly_detector.sv
// Top level of the windowed average anomaly detector: microcoded sequencer,
// ring window memory, multiplier and radix-2 divider. Depends on waad_pkg.
//
// Usage
//   Input channel (in_valid / in_stall): one beat carries one Q16.16 cost
//   sample. A beat is taken only while the sequencer sits at its wait step.
//   Result channel (out_valid / out_stall): one beat per sample with the
//   anomaly flag, the new window average and the saturating grand total.
//   Config channel (cfg_valid / cfg_ready): writes threshold_ratio (Q8.8);
//   cfg_ready is high outside reset, a zero ratio acts as 2.0.
// Sequence
//   After an input beat the sequencer steps through multiply, compare, window
//   update, grand total, divider load and the restoring divider steps, one
//   quotient bit per step over the SUM_W = 32 + clog2(WINDOW_DEPTH) bits of
//   the window sum, and then loads the result register. One sample is worked
//   at a time: the next input beat is taken only after the result loads.
// Reset
//   rst_n (synchronous) empties the window, clears the baseline and the
//   grand total and sets the ratio to 2.0. The window memory is not cleared.
// Stall
//   A result held by out_stall parks the sequencer at its final step; the
//   next input beat can still be taken once that result is loaded.
module windowed_average_anomaly_detector #(
  parameter int WINDOW_DEPTH = waad_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [waad_pkg::SAMPLE_W-1:0] in_sample_cost,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_anomaly,
  output logic [waad_pkg::SAMPLE_W-1:0] out_baseline_out,
  output logic [waad_pkg::TOTAL_W-1:0]  out_running_total,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [waad_pkg::RATIO_W-1:0]  cfg_threshold_ratio
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int FC_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = waad_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam int SW     = waad_pkg::SAMPLE_W;

  // Sequencer
  waad_pkg::step_t  pc_r, pc_nxt;
  waad_pkg::ucode_t uw;
  logic             taken;
  logic             in_beat;
  logic             out_free;
  logic             out_load;

  // Datapath registers
  logic [SW-1:0]                      sample_r;
  logic [SW-1:0]                      old_r;
  logic [waad_pkg::PROD_W-1:0]        prod_r;
  logic                               flag_r;
  logic [SLOT_W-1:0]                  slot_r;
  logic [FC_W-1:0]                    fill_r;
  logic [SUM_W-1:0]                   wsum_r;
  logic [SW-1:0]                      baseline_r;
  logic [waad_pkg::TOTAL_W-1:0]       gtotal_r;
  logic [waad_pkg::RATIO_W-1:0]       ratio_r;
  logic [SUM_W-1:0]                   quo_r;
  logic [FC_W-1:0]                    rem_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic                               out_valid_r;

  // Window memory
  logic [SW-1:0] ring_mem [WINDOW_DEPTH];

  // Combinational helpers
  logic [waad_pkg::RATIO_W-1:0] ratio_eff;
  logic [waad_pkg::PROD_W-1:0]  shifted;
  logic                         full;
  logic [FC_W:0]                trial;
  logic                         trial_ge;
  logic [waad_pkg::TOTAL_W:0]   gsum;

  assign uw        = waad_pkg::ucode_rom(pc_r);
  assign in_stall  = !rst_n || (pc_r != waad_pkg::ST_WAIT);
  assign in_beat   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = uw.load_out && out_free;
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;

  assign ratio_eff = (ratio_r == '0) ? waad_pkg::DEFAULT_RATIO : ratio_r;
  assign shifted   = {{(waad_pkg::PROD_W - SW - waad_pkg::FRAC_SHIFT){1'b0}},
                      sample_r, {waad_pkg::FRAC_SHIFT{1'b0}}};
  assign full      = (fill_r == FC_W'(WINDOW_DEPTH));
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge  = (trial >= {1'b0, fill_r});
  assign gsum      = {1'b0, gtotal_r} + (waad_pkg::TOTAL_W + 1)'(sample_r);

  // Jump decision
  always_comb begin
    unique case (uw.cond)
      waad_pkg::C_NONE:     taken = 1'b0;
      waad_pkg::C_ALWAYS:   taken = 1'b1;
      waad_pkg::C_NO_IN:    taken = !in_beat;
      waad_pkg::C_DIV_MORE: taken = (cnt_r > CNT_W'(1));
      waad_pkg::C_OUT_BUSY: taken = !out_free;
      default:              taken = 1'b1;
    endcase
    pc_nxt = taken ? uw.target : waad_pkg::step_t'(pc_r + 1'b1);
  end

  // Control state, config register, result handshake, window bookkeeping, grand total and divider count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= waad_pkg::ST_WAIT;
      out_valid_r <= 1'b0;
      ratio_r     <= waad_pkg::DEFAULT_RATIO;
      slot_r      <= '0;
      fill_r      <= '0;
      wsum_r      <= '0;
      baseline_r  <= '0;
      gtotal_r    <= '0;
      cnt_r       <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_valid && cfg_ready) begin
        ratio_r <= cfg_threshold_ratio;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        baseline_r  <= quo_r[SW-1:0];
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (uw.op)
        waad_pkg::OP_WIN: begin
          if (full) begin
            wsum_r <= wsum_r - SUM_W'(old_r) + SUM_W'(sample_r);
          end else begin
            wsum_r <= wsum_r + SUM_W'(sample_r);
            fill_r <= fill_r + 1'b1;
          end
          slot_r <= (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        end
        waad_pkg::OP_TOTAL: begin
          gtotal_r <= gsum[waad_pkg::TOTAL_W] ? '1 : gsum[waad_pkg::TOTAL_W-1:0];
        end
        waad_pkg::OP_DIV_INIT: cnt_r <= CNT_W'(SUM_W);
        waad_pkg::OP_DIV_STEP: cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    case (uw.op)
      waad_pkg::OP_ACCEPT: begin
        if (in_beat) begin
          sample_r <= in_sample_cost;
        end
      end
      waad_pkg::OP_MUL: prod_r <= baseline_r * ratio_eff;
      waad_pkg::OP_CMP: begin
        flag_r <= (fill_r >= FC_W'(waad_pkg::MIN_STORED)) && (shifted > prod_r);
      end
      waad_pkg::OP_DIV_INIT: begin
        quo_r <= wsum_r;
        rem_r <= '0;
      end
      waad_pkg::OP_DIV_STEP: begin
        // restoring step: shift in one dividend bit, subtract if it fits
        if (trial_ge) begin
          rem_r <= FC_W'(trial - {1'b0, fill_r});
        end else begin
          rem_r <= trial[FC_W-1:0];
        end
        quo_r <= {quo_r[SUM_W-2:0], trial_ge};
      end
      default: ;
    endcase
    if (out_load) begin
      out_is_anomaly    <= flag_r;
      out_baseline_out  <= quo_r[SW-1:0];
      out_running_total <= gtotal_r;
    end
  end

  // Window memory: oldest entry read at the wait step, new sample written
  always_ff @(posedge clk) begin
    if (uw.op == waad_pkg::OP_ACCEPT) begin
      old_r <= ring_mem[slot_r];
    end
    if (uw.op == waad_pkg::OP_WIN) begin
      ring_mem[slot_r] <= sample_r;
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for windowed_average_anomaly_detector: random and
// directed cost samples, ratio writes between phases, beat-level result checks.
// Depends on waad_pkg and the detector RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SW             = waad_pkg::SAMPLE_W;
  localparam int          TW             = waad_pkg::TOTAL_W;
  localparam int          RW             = waad_pkg::RATIO_W;
  localparam int          DEPTH          = waad_pkg::WINDOW_DEPTH_DEF;
  localparam int          ITEMS_PER_HALF = 155;
  localparam int          LONG_HOLD      = 400;
  localparam int          TAIL_CYCLES    = 3 * (8 + SW + $clog2(DEPTH));
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic          flag;
    logic [SW-1:0] baseline;
    logic [TW-1:0] total;
  } window_result_t;

  // Window average predictor and the queue of results still owed by the block
  class window_scoreboard;
    logic [SW-1:0]  ring [DEPTH];
    int unsigned    wr_slot;
    int unsigned    fill;
    logic [35:0]    win_sum;
    logic [SW-1:0]  baseline;
    logic [TW-1:0]  grand;
    logic [RW-1:0]  ratio;
    window_result_t owed_q[$];
    int             mismatches;

    function new();
      wr_slot    = 0;
      fill       = 0;
      win_sum    = '0;
      baseline   = '0;
      grand      = '0;
      ratio      = waad_pkg::DEFAULT_RATIO;
      mismatches = 0;
    endfunction

    function void set_ratio(logic [RW-1:0] value);
      ratio = value;
    endfunction

    // a zero ratio falls back to 2.0
    function logic [63:0] eff_ratio();
      return (ratio == '0) ? 64'(waad_pkg::DEFAULT_RATIO) : 64'(ratio);
    endfunction

    // largest sample that is still not an anomaly
    function logic [63:0] threshold_edge();
      return (64'(baseline) * eff_ratio()) >> waad_pkg::FRAC_SHIFT;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_sample(logic [SW-1:0] cost);
      window_result_t r;
      logic [64:0]    sum;
      // flag uses the baseline from before this sample
      r.flag = (fill >= waad_pkg::MIN_STORED) &&
               ((64'(cost) << waad_pkg::FRAC_SHIFT) > 64'(baseline) * eff_ratio());
      // full window: drop the oldest entry before overwriting it
      if (fill >= DEPTH) begin
        win_sum = win_sum - 36'(ring[wr_slot]);
      end else begin
        fill++;
      end
      ring[wr_slot] = cost;
      win_sum       = win_sum + 36'(cost);
      wr_slot       = (wr_slot + 1) % DEPTH;
      // saturating grand total; needs ~2^32 samples, out of reach in one run
      sum   = 65'(grand) + 65'(cost);
      grand = sum[64] ? '1 : sum[63:0];
      baseline = 32'(64'(win_sum) / 64'(fill));
      r.baseline = baseline;
      r.total    = grand;
      owed_q.push_back(r);
    endfunction

    function void check_result(logic flag, logic [SW-1:0] base,
                               logic [TW-1:0] total);
      window_result_t e;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing owed: flag %0b baseline %h total %h",
                   $time, flag, base, total);
        return;
      end
      e = owed_q.pop_front();
      if (e.flag !== flag || e.baseline !== base || e.total !== total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: flag %0b/%0b baseline %h/%h total %h/%h (exp/got)",
                   $time, e.flag, flag, e.baseline, base, e.total, total);
      end
    endfunction
  endclass

  logic          clk                 = 1'b0;
  logic          rst_n               = 1'b0;
  logic          in_valid            = 1'b0;
  logic          in_stall;
  logic [SW-1:0] in_sample_cost      = '0;
  logic          out_valid;
  logic          out_stall           = 1'b0;
  logic          out_is_anomaly;
  logic [SW-1:0] out_baseline_out;
  logic [TW-1:0] out_running_total;
  logic          cfg_valid           = 1'b0;
  logic          cfg_ready;
  logic [RW-1:0] cfg_threshold_ratio = '0;

  window_scoreboard sb;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_req      = 0;
  int               hold_left     = 0;
  int unsigned      cycle_count   = 0;

  windowed_average_anomaly_detector u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_cost     (in_sample_cost),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_anomaly     (out_is_anomaly),
    .out_baseline_out   (out_baseline_out),
    .out_running_total  (out_running_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_threshold_ratio(cfg_threshold_ratio)
  );

  always #2 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != 0) begin
      out_stall <= 1'b1;
      hold_left = LONG_HOLD - 1;
      hold_req  = 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result beats and the run-time guard
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_is_anomaly, out_baseline_out, out_running_total);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One sample beat, after a random gap; the predictor is fed on acceptance
  task automatic send_cost(input logic [SW-1:0] cost);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_sample_cost <= cost;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_sample(cost);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [RW-1:0] value);
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_threshold_ratio <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_ratio(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SW-1:0] clamp_cost(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[SW-1:0];
  endfunction

  // Mostly samples around the anomaly edge and the baseline, some noise
  function automatic logic [SW-1:0] pick_cost();
    int          roll;
    logic [63:0] thr;
    logic [63:0] base;
    logic [63:0] v;
    roll = $urandom_range(0, 99);
    thr  = sb.threshold_edge();
    base = 64'(sb.baseline);
    if (roll < 35) begin
      v = thr + 64'($urandom_range(0, 4));
      v = (v >= 2) ? v - 2 : 64'd0;
    end else if (roll < 55) begin
      v = base - (base >> 2) + 64'($urandom_range(0, 32'(base >> 1)));
    end else if (roll < 70) begin
      v = 64'($urandom());
    end else if (roll < 85) begin
      v = 64'($urandom_range(0, 32'h3FFFF));
    end else if (roll < 92) begin
      v = 64'd0;
    end else begin
      v = 64'(32'hFFFF_FFFF - $urandom_range(0, 255));
    end
    return clamp_cost(v);
  endfunction

  initial begin
    logic [RW-1:0] ratio_plan [6];
    int            phase;
    int            half;
    int            n;
    sb = new();
    ratio_plan[0] = 16'h0001;
    ratio_plan[1] = 16'h0100;
    ratio_plan[2] = 16'hFFFF;
    ratio_plan[3] = 16'($urandom_range(2, 65534));
    ratio_plan[4] = 16'h0180;
    ratio_plan[5] = waad_pkg::DEFAULT_RATIO;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero ratio acting as 2.0, short window, extremes, wrap, edge
    write_ratio(16'h0000);
    send_cost(32'h0);
    send_cost(32'h0);
    send_cost(32'h0);
    send_cost(32'h1);
    send_cost(32'h0);
    send_cost(32'hFFFF_FFFF);
    for (n = 0; n < 12; n++) send_cost(32'hFFFF_FFFF);
    for (n = 0; n < 3; n++) send_cost(32'h0001_0000);
    send_cost(clamp_cost(sb.threshold_edge()));
    send_cost(clamp_cost(sb.threshold_edge() + 1));
    drain();

    // Random phases: receiver-heavy idling, sender-heavy idling, none
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 37 : 0;
      for (half = 0; half < 2; half++) begin
        write_ratio(ratio_plan[phase * 2 + half]);
        if (half == 0 && phase != 1) hold_req = 1;
        for (n = 0; n < ITEMS_PER_HALF; n++) send_cost(pick_cost());
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/waad_pkg.sv
hw/rtl/windowed_average_anomaly_detector.sv
sim/testbench.sv
